/* design/huia_pkg.sv */
// Shared constants, codes and controller/datapath bundles for the hash
// unique index assigner. No dependencies.
package huia_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_WIDTH_DEF   = 64;

   localparam int PORT_KEY_W = 64;
   localparam int SLOT_W     = 10;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int CFG_W      = 11;
   localparam int ACT_W      = 2;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;

   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

   // murmur3 x86_32 constants
   localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2  = 32'h1b873593;
   localparam logic [31:0] MM_M5  = 32'd5;
   localparam logic [31:0] MM_N   = 32'he6546b64;
   localparam logic [31:0] MM_F1  = 32'h85ebca6b;
   localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

   // remainder unit: bits retired per cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = 32 / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic hash_start;
      logic div_start;
      logic pos_load;
      logic probe_rd;
      logic probe_eval;
      logic dump_rd;
      logic dump_eval;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hash_done;
      logic div_done;
      logic probe_empty;
      logic probe_match;
      logic probe_last;
   } status_type;

endpackage

/* design/huia_hash.sv */
// Iterative murmur3 x86_32 (seed 0) over the low key bytes, one 32x32
// multiply per cycle. Depends on huia_pkg.
module huia_hash #(
   parameter int KEY_WIDTH = huia_pkg::KEY_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [huia_pkg::PORT_KEY_W-1:0] key,
   output logic                            done,
   output logic [31:0]                     hash
);

   localparam int KEY_BYTES = (KEY_WIDTH + 7) / 8;
   localparam int NBLK      = KEY_BYTES / 4;
   localparam int REST      = KEY_BYTES % 4;
   localparam logic [31:0] KB = 32'(KEY_BYTES);

   typedef enum logic [7:0] {
      H_IDLE = 8'b00000001,
      H_B0   = 8'b00000010,
      H_B1   = 8'b00000100,
      H_B2   = 8'b00001000,
      H_T0   = 8'b00010000,
      H_T1   = 8'b00100000,
      H_F0   = 8'b01000000,
      H_F1   = 8'b10000000
   } hph_type;

   localparam hph_type FIRST_PH = (NBLK > 0) ? H_B0 : ((REST != 0) ? H_T0 : H_F0);
   localparam hph_type AFTER_BLK = (REST != 0) ? H_T0 : H_F0;

   hph_type ph_ff, ph_in;
   logic    done_ff, done_in;
   logic    blk_ff, blk_in;
   logic [31:0] h_ff, h_in, k_ff, k_in;
   logic [huia_pkg::PORT_KEY_W-1:0] key_ff, key_in;

   logic [31:0] mul_a, mul_b, word_blk, word_tail, x;
   logic [63:0] prod_full;
   logic [31:0] prod;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
      rotl = (v << r) | (v >> (32 - r));
   endfunction

   assign word_blk  = blk_ff ? key_ff[63:32] : key_ff[31:0];
   assign word_tail = (NBLK == 0) ? key_ff[31:0] : key_ff[63:32];
   assign x         = h_ff ^ k_ff ^ KB;
   assign prod_full = mul_a * mul_b;
   assign prod      = prod_full[31:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ph_ff)
         H_B0: begin mul_a = word_blk;                mul_b = huia_pkg::MM_C1; end
         H_B1: begin mul_a = rotl(k_ff, 15);          mul_b = huia_pkg::MM_C2; end
         H_B2: begin mul_a = rotl(h_ff ^ k_ff, 13);   mul_b = huia_pkg::MM_M5; end
         H_T0: begin mul_a = word_tail;               mul_b = huia_pkg::MM_C1; end
         H_T1: begin mul_a = rotl(k_ff, 15);          mul_b = huia_pkg::MM_C2; end
         H_F0: begin mul_a = x ^ (x >> 16);           mul_b = huia_pkg::MM_F1; end
         H_F1: begin mul_a = h_ff ^ (h_ff >> 13);     mul_b = huia_pkg::MM_F2; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      ph_in   = ph_ff;
      done_in = 1'b0;
      blk_in  = blk_ff;
      h_in    = h_ff;
      k_in    = k_ff;
      key_in  = key_ff;
      case (ph_ff)
         H_IDLE: begin
            if (start) begin
               h_in   = '0;
               k_in   = '0;
               blk_in = 1'b0;
               key_in = key;
               ph_in  = FIRST_PH;
            end
         end
         H_B0: begin k_in = prod; ph_in = H_B1; end
         H_B1: begin k_in = prod; ph_in = H_B2; end
         H_B2: begin
            h_in = prod + huia_pkg::MM_N;
            k_in = '0;
            if (32'(blk_ff) == NBLK - 1) begin
               ph_in = AFTER_BLK;
            end else begin
               blk_in = 1'b1;
               ph_in  = H_B0;
            end
         end
         H_T0: begin k_in = prod; ph_in = H_T1; end
         H_T1: begin k_in = prod; ph_in = H_F0; end
         H_F0: begin h_in = prod; ph_in = H_F1; end
         H_F1: begin
            h_in    = prod;
            done_in = 1'b1;
            ph_in   = H_IDLE;
         end
         default: ph_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= H_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      h_ff   <= h_in;
      k_ff   <= k_in;
      key_ff <= key_in;
   end

   assign done = done_ff;
   assign hash = h_ff ^ (h_ff >> 16);

endmodule

/* design/huia_mod.sv */
// Restoring remainder unit: 32-bit hash modulo the active table size,
// a few quotient bits per cycle. Depends on huia_pkg.
module huia_mod #(
   parameter int SIZE_W = 11,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [ADDR_W-1:0] rem
);

   localparam int CW = huia_pkg::DIV_CNT_W;

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [31:0]       num_ff, num_in;
   logic [SIZE_W:0]   rem_ff, rem_in;
   logic [SIZE_W-1:0] div_ff, div_in;

   logic [SIZE_W:0] r;
   logic [31:0]     n;

   always_comb begin
      r = rem_ff;
      n = num_ff;
      for (int i = 0; i < huia_pkg::DIV_BITS; i++) begin
         r = {r[SIZE_W-1:0], n[31]};
         n = {n[30:0], 1'b0};
         if (r >= {1'b0, div_ff}) r = r - {1'b0, div_ff};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         num_in = n;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(huia_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[ADDR_W-1:0];

endmodule

/* design/huia_datapath.sv */
// Datapath: slot memories, probe position, unique counter, size register,
// result and response registers. Depends on huia_pkg, huia_hash, huia_mod.
module huia_datapath #(
   parameter int TABLE_DEPTH = huia_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_WIDTH   = huia_pkg::KEY_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [huia_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [huia_pkg::ACT_W-1:0]      req_tuser,
   output logic [huia_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic [huia_pkg::CFG_W-1:0]      csr_wdata,
   input  huia_pkg::cmd_type               cmd,
   output huia_pkg::status_type            sts
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
   localparam int KW     = KEY_WIDTH;
   localparam int IW     = huia_pkg::IDX_W;
   localparam int CW     = huia_pkg::CNT_W;
   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_WIDTH);
   localparam logic [KW-1:0] EMPTY = {KW{1'b1}};

   logic [KW-1:0] key_mem [TABLE_DEPTH];
   logic [IW-1:0] idx_mem [TABLE_DEPTH];

   logic [CW-1:0]     count_ff;
   logic [huia_pkg::CFG_W-1:0] tsize_ff;
   logic [ADDR_W-1:0] clr_ff, pos_ff, slot_ff;
   logic [SIZE_W-1:0] size_ff, size_in, n_ff;
   logic [KW-1:0]     key_ff, rd_key_ff, res_key_ff;
   logic [IW-1:0]     rd_idx_ff, res_idx_ff;
   logic              inrange_ff, res_new_ff, res_full_ff, res_used_ff;
   logic [huia_pkg::RSP_DATA_W-1:0] rsp_ff;

   logic [63:0]       key_m, key_fold;
   logic [31:0]       slot_ext, hash_val;
   logic              hash_done, div_done;
   logic [ADDR_W-1:0] rem, rd_addr, waddr;
   logic [SIZE_W-1:0] pos_nx;
   logic              probe_empty, probe_match, probe_last;
   logic              we_key, we_idx;
   logic [KW-1:0]     wkey;

   assign key_m    = req_tdata[63:0] & KEY_MASK;
   assign key_fold = (key_m == KEY_MASK) ? 64'd0 : key_m;
   assign slot_ext = 32'(req_tdata[73:64]);

   always_comb begin
      if (tsize_ff == '0) size_in = SIZE_W'(1);
      else if (32'(tsize_ff) > TABLE_DEPTH) size_in = SIZE_W'(TABLE_DEPTH);
      else size_in = SIZE_W'(tsize_ff);
   end

   huia_hash #(.KEY_WIDTH(KEY_WIDTH)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.hash_start),
      .key   (key_fold),
      .done  (hash_done),
      .hash  (hash_val)
   );

   huia_mod #(.SIZE_W(SIZE_W), .ADDR_W(ADDR_W)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (hash_val),
      .divisor  (size_ff),
      .done     (div_done),
      .rem      (rem)
   );

   assign probe_empty = (rd_key_ff == EMPTY);
   assign probe_match = (rd_key_ff == key_ff);
   assign probe_last  = ((n_ff + 1'b1) == size_ff);
   assign pos_nx      = SIZE_W'(pos_ff) + 1'b1;

   assign sts.clr_last    = (clr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign sts.hash_done   = hash_done;
   assign sts.div_done    = div_done;
   assign sts.probe_empty = probe_empty;
   assign sts.probe_match = probe_match;
   assign sts.probe_last  = probe_last;

   // memory ports
   assign rd_addr = cmd.probe_rd ? pos_ff : slot_ff;
   assign we_idx  = cmd.probe_eval && probe_empty;
   assign we_key  = cmd.clr_step || we_idx;
   assign waddr   = cmd.clr_step ? clr_ff : pos_ff;
   assign wkey    = cmd.clr_step ? EMPTY : key_ff;

   always_ff @(posedge clock) begin
      if (we_key) key_mem[waddr] <= wkey;
      if (we_idx) idx_mem[waddr] <= count_ff[IW-1:0];
      if (cmd.probe_rd || cmd.dump_rd) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_idx_ff <= idx_mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= huia_pkg::TABLE_SIZE_RST;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_valid) tsize_ff <= csr_wdata;
         if (cmd.accept && req_tuser == huia_pkg::ACT_CLEAR) count_ff <= '0;
         else if (we_idx) count_ff <= count_ff + 1'b1;
         if (cmd.clr_step) clr_ff <= sts.clr_last ? '0 : clr_ff + 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff      <= key_fold[KW-1:0];
         slot_ff     <= slot_ext[ADDR_W-1:0];
         inrange_ff  <= (slot_ext < TABLE_DEPTH);
         size_ff     <= size_in;
         res_idx_ff  <= '0;
         res_new_ff  <= 1'b0;
         res_full_ff <= 1'b0;
         res_used_ff <= 1'b0;
         res_key_ff  <= '0;
      end
      if (cmd.pos_load) begin
         pos_ff <= rem;
         n_ff   <= '0;
      end
      if (cmd.probe_eval) begin
         if (probe_empty) begin
            res_idx_ff <= count_ff[IW-1:0];
            res_new_ff <= 1'b1;
         end else if (probe_match) begin
            res_idx_ff <= rd_idx_ff;
         end else if (probe_last) begin
            res_full_ff <= 1'b1;
         end else begin
            pos_ff <= (pos_nx == size_ff) ? '0 : pos_nx[ADDR_W-1:0];
            n_ff   <= n_ff + 1'b1;
         end
      end
      if (cmd.dump_eval && inrange_ff && !probe_empty) begin
         res_used_ff <= 1'b1;
         res_key_ff  <= rd_key_ff;
         res_idx_ff  <= rd_idx_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= {count_ff, 64'(res_key_ff), res_used_ff, res_full_ff,
                    res_new_ff, res_idx_ff};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

/* design/huia_ctrl.sv */
// Controller state machine: sequences clear sweeps, hash, remainder,
// probes and dumps, and owns the response valid. Depends on huia_pkg.
module huia_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [huia_pkg::ACT_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output huia_pkg::cmd_type          cmd,
   input  huia_pkg::status_type       sts
);

   typedef enum logic [9:0] {
      S_INIT  = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_CLEAR = 10'b0000000100,
      S_HASH  = 10'b0000001000,
      S_MOD   = 10'b0000010000,
      S_PRD   = 10'b0000100000,
      S_PCMP  = 10'b0001000000,
      S_DRD   = 10'b0010000000,
      S_DEVAL = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               case (req_tuser)
                  huia_pkg::ACT_CLEAR: state_in = S_CLEAR;
                  huia_pkg::ACT_INSERT: begin
                     cmd.hash_start = 1'b1;
                     state_in       = S_HASH;
                  end
                  huia_pkg::ACT_DUMP: state_in = S_DRD;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_DONE;
         end
         S_HASH: begin
            if (sts.hash_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_MOD;
            end
         end
         S_MOD: begin
            if (sts.div_done) begin
               cmd.pos_load = 1'b1;
               state_in     = S_PRD;
            end
         end
         S_PRD: begin
            cmd.probe_rd = 1'b1;
            state_in     = S_PCMP;
         end
         S_PCMP: begin
            cmd.probe_eval = 1'b1;
            if (sts.probe_empty || sts.probe_match || sts.probe_last) state_in = S_DONE;
            else state_in = S_PRD;
         end
         S_DRD: begin
            cmd.dump_rd = 1'b1;
            state_in    = S_DEVAL;
         end
         S_DEVAL: begin
            cmd.dump_eval = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* design/hash_unique_index_assigner.sv */
// Top level of the hash unique index assigner: controller plus datapath.
// Depends on huia_pkg, huia_ctrl, huia_datapath.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid/req_tready   | tdata: key, slot; tuser: action
//  rsp     | out | rsp_tvalid/rsp_tready   | tdata: index, flags, key, count
//  csr     | in  | csr_valid/csr_ready     | csr_wdata: table_size
//
// Insert: accept, hash (B0, B1, B2 per 32-bit key word, T0, T1 for a
//   partial word, F0, F1 final), remainder, position load, then per probed
//   slot a read on the single memory read port and a compare, then the
//   response load. Dump reads and checks one slot; clear sweeps all slots.
// After reset a clearing pass over all slots runs before req_tready.
// One request at a time; the next is taken while a response waits in the
// output register, and a stalled response holds only the finishing step.
module hash_unique_index_assigner #(
   parameter int TABLE_DEPTH = huia_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_WIDTH   = huia_pkg::KEY_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [63:0] key, [73:64] slot, [79:74] zero
   input  logic [huia_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [huia_pkg::ACT_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] unique_index, [10] was_new, [11] table_full, [12] slot_used,
   // [76:13] slot_key, [87:77] unique_count
   output logic [huia_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [huia_pkg::CFG_W-1:0]      csr_wdata
);

   huia_pkg::cmd_type    cmd;
   huia_pkg::status_type sts;

   assign csr_ready = 1'b1;

   huia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   huia_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* design/huia_checker.sv */
// Port-level checks for the hash unique index assigner, bound to the top.
// Depends on huia_pkg and hash_unique_index_assigner.
module huia_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [huia_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

   // a new key gets the count before this insert
   a_new_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |->
         rsp_tdata[9:0] == 10'(rsp_tdata[87:77] - 11'd1))
      else $error("new index does not follow unique count");

   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[10] && rsp_tdata[11]) &&
         !(rsp_tdata[12] && (rsp_tdata[10] || rsp_tdata[11])))
      else $error("insert and dump flags mixed");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[9:0] == 10'd0 &&
         rsp_tdata[76:13] == 64'd0)
      else $error("full table response carries data");

endmodule

bind hash_unique_index_assigner huia_checker u_huia_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
